@@ hw/rtl/four_class_slab_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// Slab allocator assertion macros
// Property shorthands used by the slab allocator checks.
// ----------------------------------------------------------------------------
`ifndef FOUR_CLASS_SLAB_ALLOCATOR_ASSERT_SVH
`define FOUR_CLASS_SLAB_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define FCSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fcsa: same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define FCSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fcsa: next-cycle check failed");

`endif

@@ hw/rtl/fcsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Slab allocator package
// Shared widths, codes, control structs and helper functions.
// ----------------------------------------------------------------------------
package fcsa_pkg;

	localparam int unsigned DEF_REGION_BYTES = 1024;
	localparam int unsigned NUM_CLASSES      = 4;
	localparam int unsigned ADDR_W           = 32;
	localparam int unsigned CFG_IDX_W        = 8;
	localparam int unsigned WORD_BITS        = 64;
	localparam int unsigned BIT_IDX_W        = 6;
	localparam int unsigned MAX_SIZE         = 64;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_TOO_LARGE   = 2'd1,
		ST_CLASS_FULL  = 2'd2,
		ST_BAD_ADDRESS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CLS_8  = 2'd0,
		CLS_16 = 2'd1,
		CLS_32 = 2'd2,
		CLS_64 = 2'd3
	} class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_CLASS8  = 8'd0,
		REG_BASE_CLASS16 = 8'd1,
		REG_BASE_CLASS32 = 8'd2,
		REG_BASE_CLASS64 = 8'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		RES_TOO_LARGE   = 3'd0,
		RES_BAD_ADDRESS = 3'd1,
		RES_FREED       = 3'd2,
		RES_SCAN        = 3'd3,
		RES_HELD        = 3'd4
	} res_kind_t;

	typedef struct packed {
		logic      start;
		logic      scan_next;
		logic      commit;
		logic      out_load;
		logic      res_save;
		res_kind_t res_kind;
	} fcsa_cmd_t;

	typedef struct packed {
		logic is_free;
		logic too_large;
		logic free_hit;
		logic scan_done;
	} fcsa_sts_t;

	typedef struct packed {
		logic                 found;
		logic [BIT_IDX_W-1:0] idx;
	} ffz_t;

	function automatic logic [2:0] slot_shift(input class_t c);
		logic [2:0] s;
		case (c)
			CLS_8:   s = 3'd3;
			CLS_16:  s = 3'd4;
			CLS_32:  s = 3'd5;
			default: s = 3'd6;
		endcase
		return s;
	endfunction

	// Lowest zero bit of a bitmap word, found per byte and then across bytes.
	function automatic ffz_t find_first_zero(input logic [WORD_BITS-1:0] word);
		logic [7:0]      grp_any;
		logic [7:0][2:0] grp_idx;
		ffz_t            r;
		grp_any = '0;
		grp_idx = '0;
		r       = '0;
		for (int g = 0; g < 8; g++) begin
			for (int b = 7; b >= 0; b--) begin
				if (!word[g*8+b]) begin
					grp_any[g] = 1'b1;
					grp_idx[g] = 3'(b);
				end
			end
		end
		for (int g = 7; g >= 0; g--) begin
			if (grp_any[g]) begin
				r.found = 1'b1;
				r.idx   = {3'(g), grp_idx[g]};
			end
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/fcsa_if.sv @@
// ----------------------------------------------------------------------------
// Slab allocator channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fcsa_req_if import fcsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [ADDR_W-1:0] request_size;
	logic [ADDR_W-1:0] free_address;

	modport source (output valid, req_type, request_size, free_address, input ready);
	modport sink (input valid, req_type, request_size, free_address, output ready);
endinterface

interface fcsa_rsp_if import fcsa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] slot_address;
	logic [1:0]        status;

	modport source (output valid, slot_address, status, input ready);
	modport sink (input valid, slot_address, status, output ready);
endinterface

interface fcsa_cfg_if import fcsa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [ADDR_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/fcsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// Slab allocator controller
// Sequences accept, bitmap scan or release, and result hand-off.
// ----------------------------------------------------------------------------
module fcsa_ctrl import fcsa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  fcsa_sts_t sts,
	output fcsa_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_SCAN    = 4'b0010,
		S_FREE_WR = 4'b0100,
		S_HOLD    = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.res_kind = RES_HELD;
		state_d      = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (sts.is_free && !sts.free_hit) begin
						cmd.res_kind = RES_BAD_ADDRESS;
						cmd.out_load = out_free;
						cmd.res_save = !out_free;
						state_d      = out_free ? S_IDLE : S_HOLD;
					end else if (!sts.is_free && sts.too_large) begin
						cmd.res_kind = RES_TOO_LARGE;
						cmd.out_load = out_free;
						cmd.res_save = !out_free;
						state_d      = out_free ? S_IDLE : S_HOLD;
					end else begin
						cmd.start = 1'b1;
						state_d   = sts.is_free ? S_FREE_WR : S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (!sts.scan_done) begin
					cmd.scan_next = 1'b1;
				end else begin
					cmd.commit   = 1'b1;
					cmd.res_kind = RES_SCAN;
					cmd.out_load = out_free;
					cmd.res_save = !out_free;
					state_d      = out_free ? S_IDLE : S_HOLD;
				end
			end
			S_FREE_WR: begin
				cmd.commit   = 1'b1;
				cmd.res_kind = RES_FREED;
				cmd.out_load = out_free;
				cmd.res_save = !out_free;
				state_d      = out_free ? S_IDLE : S_HOLD;
			end
			S_HOLD: begin
				cmd.res_kind = RES_HELD;
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/fcsa_dp.sv @@
// ----------------------------------------------------------------------------
// Slab allocator datapath
// Base registers, request decode, per-class bitmap memories and result regs.
// ----------------------------------------------------------------------------
module fcsa_dp import fcsa_pkg::*; #(
	parameter int unsigned REGION_BYTES = DEF_REGION_BYTES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_type,
	input  logic [ADDR_W-1:0]    request_size,
	input  logic [ADDR_W-1:0]    free_address,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  fcsa_cmd_t            cmd,
	output fcsa_sts_t            sts,
	output logic [ADDR_W-1:0]    slot_address,
	output logic [1:0]           status
);

	localparam int unsigned COUNT [NUM_CLASSES] = '{
		REGION_BYTES >> 3, REGION_BYTES >> 4, REGION_BYTES >> 5, REGION_BYTES >> 6};
	localparam int unsigned WORDS [NUM_CLASSES] = '{
		(COUNT[0] + WORD_BITS - 1) / WORD_BITS, (COUNT[1] + WORD_BITS - 1) / WORD_BITS,
		(COUNT[2] + WORD_BITS - 1) / WORD_BITS, (COUNT[3] + WORD_BITS - 1) / WORD_BITS};
	localparam int unsigned LAST_BITS [NUM_CLASSES] = '{
		COUNT[0] - WORD_BITS * (WORDS[0] - 1), COUNT[1] - WORD_BITS * (WORDS[1] - 1),
		COUNT[2] - WORD_BITS * (WORDS[2] - 1), COUNT[3] - WORD_BITS * (WORDS[3] - 1)};
	// Bits past the last real slot of a class read as taken.
	localparam logic [WORD_BITS-1:0] TAIL [NUM_CLASSES] = '{
		{WORD_BITS{1'b1}} << LAST_BITS[0], {WORD_BITS{1'b1}} << LAST_BITS[1],
		{WORD_BITS{1'b1}} << LAST_BITS[2], {WORD_BITS{1'b1}} << LAST_BITS[3]};
	localparam int unsigned WW = (WORDS[0] > 1) ? $clog2(WORDS[0]) : 1;

	logic [NUM_CLASSES-1:0][ADDR_W-1:0] base_q;

	class_t               cls_q;
	logic [WW-1:0]        word_q;
	logic [BIT_IDX_W-1:0] bit_q;
	logic                 oob_q;
	logic                 op_free_q;

	logic [ADDR_W-1:0] out_addr_q, held_addr_q;
	status_t           out_status_q, held_status_q;

	class_t                             alloc_cls, hit_cls, rd_cls;
	logic [NUM_CLASSES-1:0][ADDR_W-1:0] off;
	logic [NUM_CLASSES-1:0]             hit;
	logic [ADDR_W-1:0]                  free_slot, free_word32, slot32, alloc_addr;
	logic                               free_oob;
	logic [WW-1:0]                      rd_word;
	logic                               rd_en, wr_en, is_last, scan_done;
	logic [WORD_BITS-1:0]               map_rdata [NUM_CLASSES];
	logic [WORD_BITS-1:0]               word_data, wdata;
	ffz_t                               ffz;
	logic [ADDR_W-1:0]                  res_addr;
	status_t                            res_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BASE_CLASS8:  base_q[0] <= cfg_data;
				REG_BASE_CLASS16: base_q[1] <= cfg_data;
				REG_BASE_CLASS32: base_q[2] <= cfg_data;
				REG_BASE_CLASS64: base_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Request decode, straight from the request fields.
	always_comb begin
		if (request_size <= ADDR_W'(8)) begin
			alloc_cls = CLS_8;
		end else if (request_size <= ADDR_W'(16)) begin
			alloc_cls = CLS_16;
		end else if (request_size <= ADDR_W'(32)) begin
			alloc_cls = CLS_32;
		end else begin
			alloc_cls = CLS_64;
		end
		for (int k = 0; k < NUM_CLASSES; k++) begin
			off[k] = free_address - base_q[k];
			hit[k] = off[k] < ADDR_W'(REGION_BYTES);
		end
		hit_cls = CLS_64;
		for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
			if (hit[k]) begin
				hit_cls = class_t'(k);
			end
		end
		free_slot   = off[hit_cls] >> slot_shift(hit_cls);
		free_word32 = free_slot >> BIT_IDX_W;
		// A slot in a partial tail can sit one word past the stored bitmap.
		free_oob    = free_word32 >= ADDR_W'(WORDS[hit_cls]);
	end

	assign sts.is_free   = req_type;
	assign sts.too_large = request_size > ADDR_W'(MAX_SIZE);
	assign sts.free_hit  = |hit;
	assign sts.scan_done = scan_done;

	always_comb begin
		rd_en   = cmd.start || cmd.scan_next;
		rd_cls  = cmd.start ? (req_type ? hit_cls : alloc_cls) : cls_q;
		if (cmd.start) begin
			rd_word = req_type ? free_word32[WW-1:0] : '0;
		end else begin
			rd_word = word_q + WW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_free_q <= req_type;
			bit_q     <= free_slot[BIT_IDX_W-1:0];
			oob_q     <= free_oob;
		end
		if (rd_en) begin
			cls_q  <= rd_cls;
			word_q <= rd_word;
		end
	end

	// One bitmap memory per class; a word never written reads as all free.
	for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_map
		localparam int unsigned D = WORDS[k];
		logic [WORD_BITS-1:0] mem_q [D];
		logic [D-1:0]         vld_q;
		logic [WORD_BITS-1:0] rdata_q;
		logic                 wr_sel;

		assign wr_sel       = wr_en && (cls_q == class_t'(k));
		assign map_rdata[k] = rdata_q;

		if (D > 1) begin : g_deep
			localparam int unsigned AW = $clog2(D);
			logic [AW-1:0] rd_idx, wr_idx;

			assign rd_idx = rd_word[AW-1:0];
			assign wr_idx = word_q[AW-1:0];

			always_ff @(posedge clk) begin
				if (wr_sel) begin
					mem_q[wr_idx] <= wdata;
				end
				if (rd_en) begin
					rdata_q <= vld_q[rd_idx] ? mem_q[rd_idx] : '0;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q <= '0;
				end else if (wr_sel) begin
					vld_q[wr_idx] <= 1'b1;
				end
			end
		end else begin : g_flat
			always_ff @(posedge clk) begin
				if (wr_sel) begin
					mem_q[0] <= wdata;
				end
				if (rd_en) begin
					rdata_q <= vld_q[0] ? mem_q[0] : '0;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q <= '0;
				end else if (wr_sel) begin
					vld_q[0] <= 1'b1;
				end
			end
		end
	end

	// Scan of the word read in the previous cycle.
	always_comb begin
		word_data  = map_rdata[cls_q];
		is_last    = (word_q == WW'(WORDS[cls_q] - 1));
		ffz        = find_first_zero(word_data | (is_last ? TAIL[cls_q] : '0));
		scan_done  = ffz.found || is_last;
		slot32     = ADDR_W'({word_q, ffz.idx});
		alloc_addr = base_q[cls_q] + (slot32 << slot_shift(cls_q));
		if (op_free_q) begin
			wdata = word_data & ~(WORD_BITS'(1) << bit_q);
			wr_en = cmd.commit && !oob_q;
		end else begin
			wdata = word_data | (WORD_BITS'(1) << ffz.idx);
			wr_en = cmd.commit && ffz.found;
		end
	end

	always_comb begin
		res_addr   = '0;
		res_status = ST_OK;
		unique case (cmd.res_kind)
			RES_TOO_LARGE:   res_status = ST_TOO_LARGE;
			RES_BAD_ADDRESS: res_status = ST_BAD_ADDRESS;
			RES_FREED:       res_status = ST_OK;
			RES_SCAN: begin
				if (ffz.found) begin
					res_addr = alloc_addr;
				end else begin
					res_status = ST_CLASS_FULL;
				end
			end
			RES_HELD: begin
				res_addr   = held_addr_q;
				res_status = held_status_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_save) begin
			held_addr_q   <= res_addr;
			held_status_q <= res_status;
		end
		if (cmd.out_load) begin
			out_addr_q   <= res_addr;
			out_status_q <= res_status;
		end
	end

	assign slot_address = out_addr_q;
	assign status       = out_status_q;

endmodule

@@ hw/rtl/four_class_slab_allocator.sv @@
// ----------------------------------------------------------------------------
// Four-class slab allocator
// Allocates and frees 8/16/32/64-byte slots from four bitmap-tracked regions.
// ----------------------------------------------------------------------------
// An allocate or free that touches a bitmap reads one 64-bit word of the class
// bitmap in the accept cycle, and in the state after it searches or updates
// that word and loads the result register. An allocate reads one more word for
// each fully occupied word it passes, as each bitmap memory has a single read
// port. Oversize allocates and frees outside every region finish in the accept
// cycle. The result register lets the next request be taken while a result
// waits; when it is still occupied a finished result is parked in a holding
// register until the result register frees, and no request is taken meanwhile.
// The bitmaps read as all free after reset with no clearing pass, and
// configuration writes are taken at any time.
`include "four_class_slab_allocator_assert.svh"

module four_class_slab_allocator import fcsa_pkg::*; #(
	parameter int unsigned REGION_BYTES = DEF_REGION_BYTES
) (
	input logic       clk,
	input logic       arst_n,
	fcsa_req_if.sink  req,
	fcsa_rsp_if.source rsp,
	fcsa_cfg_if.sink  cfg
);

	fcsa_cmd_t cmd;
	fcsa_sts_t sts;

	assign cfg.ready = 1'b1;

	fcsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fcsa_dp #(
		.REGION_BYTES (REGION_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_type     (req.req_type),
		.request_size (req.request_size),
		.free_address (req.free_address),
		.cfg_write    (cfg.valid && cfg.ready),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.cmd          (cmd),
		.sts          (sts),
		.slot_address (rsp.slot_address),
		.status       (rsp.status)
	);

	// A waiting result is never overwritten.
	`FCSA_ASSERT_IMP(a_no_overwrite, clk, arst_n, rsp.valid && !rsp.ready, !cmd.out_load)
	// A request that needs the bitmap keeps the input closed after it starts.
	`FCSA_ASSERT_NXT(a_busy_after_start, clk, arst_n, cmd.start, !req.ready)
	// A request that needs the bitmap cannot also produce its result at once.
	`FCSA_ASSERT_IMP(a_start_no_result, clk, arst_n, cmd.start, !cmd.out_load && !cmd.res_save)
	// Once a result is produced the scan does not continue.
	`FCSA_ASSERT_NXT(a_no_scan_after_done, clk, arst_n, cmd.out_load || cmd.res_save,
		!cmd.scan_next)

endmodule
